### src/tsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsi_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int VALUE_BITS  = 32;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    // item action codes
    typedef enum logic [1:0] {
        ACT_INSERT_SECOND = 2'd0,
        ACT_INSERT_THIRD  = 2'd1,
        ACT_PROBE         = 2'd2,
        ACT_FINISH        = 2'd3
    } action_t;

    // commands into one membership store
    typedef struct packed {
        logic insert;
        logic clear;
    } cam_cmd_t;

    // status out of one membership store
    typedef struct packed {
        logic hit;
        logic full;
    } cam_stat_t;

endpackage

`default_nettype wire

### src/tsi_cam.sv
`timescale 1ns / 1ps
`default_nettype none

module tsi_cam (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tsi_pkg::value_t   key,
    input  wire tsi_pkg::cam_cmd_t cmd,
    output tsi_pkg::cam_stat_t     stat
);
    import tsi_pkg::*;

    value_t                 entry_reg [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [STORE_DEPTH-1:0] valid_next;
    logic [STORE_DEPTH-1:0] match;
    logic [STORE_DEPTH-1:0] free_vec;
    logic [STORE_DEPTH-1:0] pick;
    logic                   do_write;

    // parallel compare, one comparator per entry
    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            match[i] = valid_reg[i] && (entry_reg[i] == key);
        end
    end

    // lowest free entry as a one-hot vector
    assign free_vec = ~valid_reg;
    assign pick     = free_vec & (~free_vec + {{(STORE_DEPTH-1){1'b0}}, 1'b1});

    assign stat.hit  = |match;
    assign stat.full = &valid_reg;
    assign do_write  = cmd.insert && !stat.hit;

    always_comb
    begin
        if (cmd.clear)
        begin
            valid_next = '0;
        end
        else if (do_write)
        begin
            valid_next = valid_reg | pick;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (do_write && pick[i])
            begin
                entry_reg[i] <= key;
            end
        end
    end

endmodule

`default_nettype wire

### src/three_way_set_intersection_top.sv
`timescale 1ns / 1ps
`default_nettype none

// finds the values common to three lists. load the second list with insert-second
// transactions and the third list with insert-third transactions (duplicates are ignored,
// a new value takes the lowest free entry, and an insert into a full 64-entry store is
// dropped and sets a sticky overflow flag). then stream the first list as probe
// transactions: a probe gives one result transaction carrying the value when it is held
// in both stores and was not reported before. a finish transaction gives one end result
// (end_mark high, common_value zero) with none_found and store_overflow, then clears
// every store and flag. inserts and probes give no result otherwise. the block takes
// one transaction per clock while result_ready keeps the output moving; a transaction
// sits in the input register while it is matched against all entries of the three
// flop-based stores in parallel, and its result is captured in the output register.
// the 64-way compare plus lowest-free-entry pick sets the clock period. when the output
// register is held by result_ready low, the item in the input register waits and
// item_ready drops.
module three_way_set_intersection_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire logic [1:0]                  action,
    input  wire logic signed [31:0]          item_value,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic signed [31:0]               common_value,
    output logic                             end_mark,
    output logic                             none_found,
    output logic                             store_overflow
);
    import tsi_pkg::*;

    // input register
    logic      item_valid_reg;
    action_t   action_reg;
    value_t    value_reg;

    // result register
    logic      result_valid_reg;
    value_t    common_value_reg;
    logic      end_mark_reg;
    logic      none_found_reg;
    logic      store_overflow_reg;

    // sticky flags since last finish
    logic      overflow_reg;
    logic      overflow_next;
    logic      emitted_any_reg;
    logic      emitted_any_next;

    cam_cmd_t  second_cmd;
    cam_cmd_t  third_cmd;
    cam_cmd_t  emitted_cmd;
    cam_stat_t second_stat;
    cam_stat_t third_stat;
    cam_stat_t emitted_stat;

    logic      fire;
    logic      accept;
    logic      is_finish;
    logic      is_probe;
    logic      emit;
    logic      produces;

    // the item in the input register moves on when the result register is free
    assign fire       = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || fire;
    assign accept     = item_valid && item_ready;

    // action decode
    always_comb
    begin
        is_finish = 1'b0;
        is_probe  = 1'b0;
        unique case (action_reg)
            ACT_INSERT_SECOND: ;
            ACT_INSERT_THIRD:  ;
            ACT_PROBE:         is_probe  = 1'b1;
            ACT_FINISH:        is_finish = 1'b1;
            default:           ;
        endcase
    end

    // new common value: in both membership stores and not yet reported
    assign emit     = fire && is_probe && second_stat.hit && third_stat.hit
                      && !emitted_stat.hit;
    assign produces = emit || (fire && is_finish);

    always_comb
    begin
        second_cmd.insert  = fire && (action_reg == ACT_INSERT_SECOND);
        second_cmd.clear   = fire && is_finish;
        third_cmd.insert   = fire && (action_reg == ACT_INSERT_THIRD);
        third_cmd.clear    = fire && is_finish;
        emitted_cmd.insert = emit;
        emitted_cmd.clear  = fire && is_finish;
    end

    tsi_cam u_second_cam (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (value_reg),
        .cmd   (second_cmd),
        .stat  (second_stat)
    );

    tsi_cam u_third_cam (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (value_reg),
        .cmd   (third_cmd),
        .stat  (third_stat)
    );

    tsi_cam u_emitted_cam (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (value_reg),
        .cmd   (emitted_cmd),
        .stat  (emitted_stat)
    );

    // overflow: a new value meets a full store; a finish clears it and the found flag
    always_comb
    begin
        if (fire && is_finish)
        begin
            overflow_next    = 1'b0;
            emitted_any_next = 1'b0;
        end
        else
        begin
            overflow_next = overflow_reg
                || (second_cmd.insert && !second_stat.hit && second_stat.full)
                || (third_cmd.insert && !third_stat.hit && third_stat.full)
                || (emit && emitted_stat.full);
            emitted_any_next = emitted_any_reg || emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            overflow_reg     <= 1'b0;
            emitted_any_reg  <= 1'b0;
        end
        else
        begin
            overflow_reg    <= overflow_next;
            emitted_any_reg <= emitted_any_next;
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                item_valid_reg <= 1'b0;
            end
            if (produces)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action_t'(action);
            value_reg  <= item_value;
        end
        if (produces)
        begin
            common_value_reg   <= is_finish ? '0 : value_reg;
            end_mark_reg       <= is_finish;
            none_found_reg     <= is_finish && !emitted_any_reg;
            store_overflow_reg <= is_finish && overflow_reg;
        end
    end

    assign result_valid   = result_valid_reg;
    assign common_value   = common_value_reg;
    assign end_mark       = end_mark_reg;
    assign none_found     = none_found_reg;
    assign store_overflow = store_overflow_reg;

endmodule

`default_nettype wire

### src/tsi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tsi_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_ready,
    input wire logic [1:0]         action,
    input wire logic signed [31:0] item_value,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire logic signed [31:0] common_value,
    input wire logic               end_mark,
    input wire logic               none_found,
    input wire logic               store_overflow
);

    // an offered item keeps its payload until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(action) && $stable(item_value))
        else $error("item transaction changed while stalled");

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(common_value)
            && $stable(end_mark) && $stable(none_found) && $stable(store_overflow))
        else $error("result transaction changed while stalled");

    // end result carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && end_mark |-> common_value == 32'sd0)
        else $error("end result with nonzero value");

    // common-value result has no end flags
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !end_mark |-> !none_found && !store_overflow)
        else $error("flags set on common-value result");

    // a reported value right before an end result means something was found
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !end_mark
            |=> !(result_valid && end_mark && none_found))
        else $error("none_found after a common value was reported");

endmodule

bind three_way_set_intersection_top tsi_checker u_tsi_checker (.*);

`default_nettype wire
